FILE: rtl/achnc_pkg.sv
// achnc_pkg: constants, sequencer states and inter-module structs for the
// achilles number classifier; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package achnc_pkg;

	localparam int NUM_WIDTH = 32;
	// exponent of any prime factor is at most NUM_WIDTH-1
	localparam int EXP_W     = $clog2(NUM_WIDTH);
	localparam int CNT_W     = $clog2(NUM_WIDTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TRIAL,
		ST_TRIAL_WAIT,
		ST_GCD,
		ST_GCD_WAIT,
		ST_TAIL,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                 start;
		logic [NUM_WIDTH-1:0] dividend;
		logic [NUM_WIDTH-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [NUM_WIDTH-1:0] quotient;
		logic [NUM_WIDTH-1:0] remainder;
	} div_rsp_t;

	typedef struct packed {
		logic prime_flag;
		logic powerful_flag;
		logic perfect_power_flag;
		logic achilles_flag;
	} result_t;

endpackage

`default_nettype wire

FILE: rtl/achnc_in_if.sv
// achnc_in_if: input channel carrying the number to classify
// depends on achnc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface achnc_in_if
	import achnc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [NUM_WIDTH-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

`default_nettype wire

FILE: rtl/achnc_out_if.sv
// achnc_out_if: result channel carrying the four classification flags
// depends on achnc_pkg
`timescale 1ns / 1ps
`default_nettype none

interface achnc_out_if
	import achnc_pkg::*;
();
	logic valid;
	logic ready;
	logic prime_flag;
	logic powerful_flag;
	logic perfect_power_flag;
	logic achilles_flag;

	modport source (output valid, output prime_flag, output powerful_flag,
		output perfect_power_flag, output achilles_flag, input ready);
	modport sink   (input valid, input prime_flag, input powerful_flag,
		input perfect_power_flag, input achilles_flag, output ready);
endinterface

`default_nettype wire

FILE: rtl/achnc_div.sv
// achnc_div: shared restoring divider, one quotient bit per cycle
// depends on achnc_pkg
`timescale 1ns / 1ps
`default_nettype none

module achnc_div
	import achnc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t div_req,
	output div_rsp_t      div_rsp
);

	localparam logic [CNT_W-1:0] CNT_INIT = CNT_W'(NUM_WIDTH);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [NUM_WIDTH-1:0] rem_q;
	logic [NUM_WIDTH-1:0] quo_q;
	logic [NUM_WIDTH-1:0] dvs_q;

	logic [NUM_WIDTH:0]   r_sh;
	logic [NUM_WIDTH:0]   diff;
	logic                 load;

	assign load = div_req.start && !busy_q;
	assign r_sh = {rem_q, quo_q[NUM_WIDTH-1]};
	assign diff = r_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_INIT;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= '0;
			quo_q <= div_req.dividend;
			dvs_q <= div_req.divisor;
		end else if (busy_q) begin
			// partial remainder stays below the divisor, so it fits the width
			if (!diff[NUM_WIDTH]) begin
				rem_q <= diff[NUM_WIDTH-1:0];
				quo_q <= {quo_q[NUM_WIDTH-2:0], 1'b1};
			end else begin
				rem_q <= r_sh[NUM_WIDTH-1:0];
				quo_q <= {quo_q[NUM_WIDTH-2:0], 1'b0};
			end
		end
	end

	assign div_rsp.busy      = busy_q;
	assign div_rsp.done      = done_q;
	assign div_rsp.quotient  = quo_q;
	assign div_rsp.remainder = rem_q;

	a_done_idle : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");

	a_done_after_busy : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a division in flight");

	a_rem_bound : assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < dvs_q))
		else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

FILE: rtl/achnc_ctrl.sv
// achnc_ctrl: trial division and exponent gcd sequencer with its datapath
// depends on achnc_pkg, achnc_in_if; drives the shared divider achnc_div
`timescale 1ns / 1ps
`default_nettype none

module achnc_ctrl
	import achnc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	achnc_in_if.sink      req,
	output div_req_t      div_req,
	input  wire div_rsp_t div_rsp,
	output logic          res_valid,
	output result_t       res,
	input  wire logic     res_take
);

	state_t state_q, state_d;

	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] d_q;
	logic [NUM_WIDTH-1:0] d_next;
	logic [EXP_W-1:0]     e_q;
	logic [EXP_W-1:0]     g_q;
	logic [EXP_W-1:0]     a_q;
	logic [EXP_W-1:0]     b_q;
	logic [1:0]           tot_q;   // sum of exponents, saturated at two
	logic                 pow_q;

	logic                 below_two;
	logic                 stop;
	logic                 exact;
	logic                 perfect;

	assign below_two = req.number < NUM_WIDTH'(2);
	// bound is checked only when a new divisor starts, not mid-exponent
	assign stop    = (e_q == '0) && (d_q > div_rsp.quotient);
	assign exact   = div_rsp.remainder == '0;
	assign d_next  = (d_q == NUM_WIDTH'(2)) ? NUM_WIDTH'(3) : d_q + NUM_WIDTH'(2);
	assign perfect = g_q >= EXP_W'(2);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = below_two ? ST_FINISH : ST_TRIAL;
			end
			ST_TRIAL: state_d = ST_TRIAL_WAIT;
			ST_TRIAL_WAIT: begin
				if (div_rsp.done) begin
					priority if (stop)         state_d = ST_TAIL;
					else if (exact)            state_d = ST_TRIAL;
					else if (e_q != '0)        state_d = ST_GCD;
					else                       state_d = ST_TRIAL;
				end
			end
			ST_GCD:      state_d = (b_q == '0) ? ST_TRIAL : ST_GCD_WAIT;
			ST_GCD_WAIT: begin
				if (div_rsp.done) state_d = ST_GCD;
			end
			ST_TAIL:     state_d = ST_FINISH;
			ST_FINISH: begin
				if (res_take) state_d = ST_IDLE;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready        = 1'b0;
		res_valid        = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = n_q;
		div_req.divisor  = d_q;
		unique case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_TRIAL:  div_req.start = 1'b1;
			ST_GCD: begin
				div_req.start    = b_q != '0;
				div_req.dividend = NUM_WIDTH'(a_q);
				div_req.divisor  = NUM_WIDTH'(b_q);
			end
			ST_FINISH: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					n_q   <= req.number;
					d_q   <= NUM_WIDTH'(2);
					e_q   <= '0;
					g_q   <= '0;
					tot_q <= 2'd0;
					pow_q <= !below_two;
				end
			end
			ST_TRIAL_WAIT: begin
				if (div_rsp.done && !stop) begin
					if (exact) begin
						n_q <= div_rsp.quotient;
						e_q <= e_q + EXP_W'(1);
					end else begin
						d_q <= d_next;
						if (e_q != '0) begin
							pow_q <= pow_q && (e_q >= EXP_W'(2));
							tot_q <= (tot_q == 2'd0 && e_q == EXP_W'(1)) ? 2'd1 : 2'd2;
							a_q   <= g_q;
							b_q   <= e_q;
						end
					end
				end
			end
			ST_GCD: begin
				if (b_q == '0) begin
					g_q <= a_q;
					e_q <= '0;
				end
			end
			ST_GCD_WAIT: begin
				if (div_rsp.done) begin
					a_q <= b_q;
					b_q <= div_rsp.remainder[EXP_W-1:0];
				end
			end
			ST_TAIL: begin
				// leftover cofactor is one more prime with exponent one
				if (n_q > NUM_WIDTH'(1)) begin
					pow_q <= 1'b0;
					g_q   <= EXP_W'(1);
					tot_q <= (tot_q == 2'd0) ? 2'd1 : 2'd2;
				end
			end
			default: ;
		endcase
	end

	assign res.prime_flag         = tot_q == 2'd1;
	assign res.powerful_flag      = pow_q;
	assign res.perfect_power_flag = perfect;
	assign res.achilles_flag      = pow_q && !perfect;

endmodule

`default_nettype wire

FILE: rtl/achilles_number_classifier.sv
// achilles_number_classifier: top level with sequencer, shared divider and
// result register; depends on achnc_pkg, achnc_in_if, achnc_out_if
// Work: each division runs on the shared divider, one division at a time; an item
// needs about one division per odd trial divisor up to sqrt(number), plus one per
// factor found and a few for each exponent gcd; a prime near 2^32 is the worst case,
// and inputs below two need no division at all.
// Throughput: one item at a time; a new item is taken while the last result waits.
// Reset: arst_n clears the sequencer, divider control and result valid at once.
`timescale 1ns / 1ps
`default_nettype none

module achilles_number_classifier
	import achnc_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	achnc_in_if.sink   req,
	achnc_out_if.source rsp
);

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     res_valid;
	result_t  res;
	logic     res_take;
	logic     ovalid_q;
	result_t  res_q;

	achnc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	achnc_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.div_req (div_req),
		.div_rsp (div_rsp)
	);

	assign res_take = !ovalid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (res_take) begin
			ovalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) res_q <= res;
	end

	assign rsp.valid              = ovalid_q;
	assign rsp.prime_flag         = res_q.prime_flag;
	assign rsp.powerful_flag      = res_q.powerful_flag;
	assign rsp.perfect_power_flag = res_q.perfect_power_flag;
	assign rsp.achilles_flag      = res_q.achilles_flag;

	a_achilles_powerful : assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !(res_q.achilles_flag && !res_q.powerful_flag))
		else $error("achilles item that is not powerful");

	a_prime_not_powerful : assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q |-> !(res_q.prime_flag && (res_q.powerful_flag || res_q.perfect_power_flag)))
		else $error("prime item flagged powerful or perfect power");

	a_ready_div_idle : assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !div_rsp.busy)
		else $error("input ready while divider busy");

endmodule

`default_nettype wire
